FILE: rtl/sttc_pkg.sv
`default_nettype none

package sttc_pkg;

  // Token type codes
  localparam logic [3:0] TypeLiteral  = 4'd0;
  localparam logic [3:0] TypeHexHash  = 4'd1;
  localparam logic [3:0] TypeNumber   = 4'd2;
  localparam logic [3:0] TypeIpv4     = 4'd3;
  localparam logic [3:0] TypeQSpace   = 4'd6;
  localparam logic [3:0] TypeFilename = 4'd7;
  localparam logic [3:0] TypeRelPath  = 4'd8;
  localparam logic [3:0] TypeAbsPath  = 4'd9;
  localparam logic [3:0] TypeUrl      = 4'd11;

  // Colon tracking for the scheme "://" test
  localparam logic [1:0] ColonNone    = 2'd0;
  localparam logic [1:0] ColonSeen    = 2'd1;
  localparam logic [1:0] ColonSlash   = 2'd2;
  localparam logic [1:0] ColonDone    = 2'd3;

  localparam logic [5:0] MinHashReset = 6'd8;
  localparam logic [5:0] LenMax       = 6'd63;
  localparam logic [2:0] DotMax       = 3'd7;
  localparam logic [2:0] Ipv4Dots     = 3'd3;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       no_char;
  } item_t;

  typedef struct packed {
    logic [5:0] chars_seen;
    logic       first_was_slash;
    logic       hex_prefix_ok;
    logic       hex_tail_ok;
    logic       all_hex;
    logic       digits_dots_only;
    logic [2:0] dot_count;
    logic       decimal_ok;
    logic [1:0] colon_phase;
    logic       scheme_alpha;
    logic       url_ok;
    logic       prev_was_dot;
    logic       has_dotdot;
    logic       has_slash;
    logic       has_dot;
    logic       has_space;
  } flags_t;

  localparam flags_t FlagsClear = '{
    chars_seen:       6'd0,
    first_was_slash:  1'b0,
    hex_prefix_ok:    1'b0,
    hex_tail_ok:      1'b1,
    all_hex:          1'b1,
    digits_dots_only: 1'b1,
    dot_count:        3'd0,
    decimal_ok:       1'b1,
    colon_phase:      ColonNone,
    scheme_alpha:     1'b1,
    url_ok:           1'b0,
    prev_was_dot:     1'b0,
    has_dotdot:       1'b0,
    has_slash:        1'b0,
    has_dot:          1'b0,
    has_space:        1'b0
  };

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sttc_track.sv
`default_nettype none

module sttc_track (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire sttc_pkg::item_t item_i,
  input  wire logic [5:0]     min_hash_length_i,
  output logic [3:0]          token_type_o
);
  import sttc_pkg::*;

  flags_t flags_q, flags_d, flags_upd;

  function automatic flags_t take_byte(input flags_t f, input logic [7:0] c);
    flags_t r;
    logic   dot;
    logic   slash;
    r     = f;
    dot   = (c == ChDot);
    slash = (c == ChSlash);
    if (f.chars_seen == 6'd0) begin
      r.first_was_slash = slash;
      r.hex_prefix_ok   = (c == ChZero);
      r.decimal_ok      = is_dec(c) || (c == ChMinus);
    end else begin
      if (f.chars_seen == 6'd1) begin
        r.hex_prefix_ok = f.hex_prefix_ok && ((c == ChLowX) || (c == ChUpX));
      end else begin
        r.hex_tail_ok = f.hex_tail_ok && is_hexd(c);
      end
      r.decimal_ok = f.decimal_ok && is_dec(c);
    end
    r.all_hex = f.all_hex && is_hexd(c);
    if (dot) begin
      if (f.dot_count < DotMax) r.dot_count = f.dot_count + 3'd1;
    end else if (!is_dec(c)) begin
      r.digits_dots_only = 1'b0;
    end
    case (f.colon_phase)
      ColonNone: begin
        if (c == ChColon) r.colon_phase = ColonSeen;
        else if (!is_letter(c)) r.scheme_alpha = 1'b0;
      end
      ColonSeen: begin
        r.colon_phase = slash ? ColonSlash : ColonDone;
      end
      ColonSlash: begin
        if (slash) r.url_ok = f.scheme_alpha;
        r.colon_phase = ColonDone;
      end
      default: begin
      end
    endcase
    if (dot && f.prev_was_dot) r.has_dotdot = 1'b1;
    r.prev_was_dot = dot;
    if (slash) r.has_slash = 1'b1;
    if (dot) r.has_dot = 1'b1;
    if ((c == ChSpace) || ((c >= ChTab) && (c <= ChCr))) r.has_space = 1'b1;
    if (f.chars_seen < LenMax) r.chars_seen = f.chars_seen + 6'd1;
    return r;
  endfunction

  function automatic logic [3:0] decide(input flags_t f, input logic [5:0] min_len);
    logic lone_minus;
    lone_minus = (f.chars_seen == 6'd1) && !f.digits_dots_only;
    if (f.chars_seen == 6'd0) return TypeLiteral;
    if (f.first_was_slash && (f.chars_seen >= 6'd2)) return TypeAbsPath;
    if (f.url_ok) return TypeUrl;
    if (f.digits_dots_only && (f.dot_count == Ipv4Dots)) return TypeIpv4;
    if (f.all_hex && (f.chars_seen >= min_len)) return TypeHexHash;
    if (f.hex_prefix_ok && (f.chars_seen >= 6'd3) && f.hex_tail_ok) return TypeNumber;
    if (f.decimal_ok && !lone_minus) return TypeNumber;
    if (!f.first_was_slash && (f.has_dotdot || f.has_slash)) return TypeRelPath;
    if (!f.has_slash && f.has_dot) return TypeFilename;
    if (f.has_space) return TypeQSpace;
    return TypeLiteral;
  endfunction

  always_comb begin
    flags_upd    = item_i.no_char ? flags_q : take_byte(flags_q, item_i.char_code);
    token_type_o = decide(flags_upd, min_hash_length_i);
    flags_d      = flags_q;
    if (step_i) begin
      flags_d = item_i.last_char ? FlagsClear : flags_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FlagsClear;
    end else begin
      flags_q <= flags_d;
    end
  end

  // token end always leaves clean flags behind
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_char |=> flags_q == FlagsClear)
    else $error("flags not cleared after token end");

  // a byte inside a token always bumps the length off zero
  a_len_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.last_char && !item_i.no_char |=> flags_q.chars_seen != 6'd0)
    else $error("length did not count a byte");

  // flags hold while no word moves
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> flags_q == $past(flags_q))
    else $error("flags changed without a word");

endmodule

`default_nettype wire

FILE: rtl/shell_token_type_classifier_unit.sv
`default_nettype none

// Channel | Dir | Handshake               | Word
// --------+-----+-------------------------+----------------------------------------
// in      | in  | in_valid_i / in_ready_o | char_code_i, last_char_i, no_char_i
// out     | out | out_valid_o/out_ready_i | token_type_o
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (min_hash_length)
//
// One word per cycle sustained, but a stalled result holds back only a last word;
// other words keep flowing. A word is held in the input register; the flag
// update and the type decision run in one shallow step from there into the
// result register, which takes a token's type as its last word leaves the
// input register. Reset clears the flags and sets min_hash_length to 8.

module shell_token_type_classifier_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       last_char_i,
  input  wire logic       no_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      token_type_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [5:0] cfg_data_i
);
  import sttc_pkg::*;

  // input register
  logic       s1_valid_q, s1_valid_d;
  item_t      s1_item_q;
  logic       s1_adv;
  logic       in_take;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [3:0] out_type_q;
  logic [3:0] type_next;

  logic [5:0] min_len_q;

  assign cfg_ready_o = 1'b1;

  // a non-last word never waits on the output side
  assign s1_adv     = s1_valid_q && (!s1_item_q.last_char || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (s1_adv && s1_item_q.last_char) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  sttc_track u_track (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s1_adv),
    .item_i           (s1_item_q),
    .min_hash_length_i(min_len_q),
    .token_type_o     (type_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      min_len_q   <= MinHashReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) min_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{char_code: char_code_i, last_char: last_char_i, no_char: no_char_i};
    end
    if (s1_adv && s1_item_q.last_char) out_type_q <= type_next;
  end

  assign out_valid_o  = out_valid_q;
  assign token_type_o = out_type_q;

  // a token end moved forward always lands in the result register
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_item_q.last_char |=> out_valid_o)
    else $error("token end produced no result");

  // a pending last word is never dropped while the result is stalled
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_item_q.last_char && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("last word lost under stall");

  // only defined type codes leave the block
  a_legal_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_type_o == TypeLiteral) || (token_type_o == TypeHexHash) ||
                    (token_type_o == TypeNumber) || (token_type_o == TypeIpv4) ||
                    (token_type_o == TypeQSpace) || (token_type_o == TypeFilename) ||
                    (token_type_o == TypeRelPath) || (token_type_o == TypeAbsPath) ||
                    (token_type_o == TypeUrl))
    else $error("undefined token type code");

  // config write takes effect on the next cycle
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> min_len_q == $past(cfg_data_i))
    else $error("min hash length not written");

endmodule

`default_nettype wire
